FILE: rtl/core/lz4d_pkg.sv
// package for the lz4 block decoder: constants, phase type and state type
`timescale 1ns / 1ps
`default_nettype none
package lz4d_pkg;
    localparam int WINDOW_DEPTH_DEF     = 65536;
    localparam int BYTES_PER_RESULT_DEF = 8;
    localparam int LEN_W = 24;
    localparam int CFG_ADDR_W = 1;

    localparam logic [3:0] RUN_MAX      = 4'd15;
    localparam logic [7:0] EXT_CONTINUE = 8'd255;
    localparam logic [4:0] MIN_MATCH    = 5'd4;
    localparam logic [4:0] END_GAP_OUT  = 5'd12;
    localparam logic [4:0] END_GAP_IN   = 5'd8;
    localparam logic [4:0] MATCH_TAIL   = 5'd5;

    localparam logic [CFG_ADDR_W-1:0] CFG_INPUT_LENGTH    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_CAPACITY = 1'b1;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_DONE    = 2'd1;
    localparam logic [1:0] ST_ERROR   = 2'd2;

    typedef enum logic [2:0] {
        PH_TOKEN, PH_LIT_EXT, PH_LITERALS, PH_LAST_LITS,
        PH_OFF_LO, PH_OFF_HI, PH_MATCH_EXT
    } t_phase;

    // sequencer states of the top level
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_COPY_RD, S_COPY_WR, S_EMIT, S_EMPTY
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/core/lz4_block_decoder.sv
// lz4 block decoder: byte parser, history window memory and result packer
//  channel | dir | handshake                  | payload
//  s_axis  | in  | s_axis_tvalid/tready       | tdata[7:0] in_byte
//  m_axis  | out | m_axis_tvalid/tready       | tdata out_bytes,byte_count,status; tlast run_last
//  cfg     | in  | i_cfg_we                   | i_cfg_idx, i_cfg_data
// every byte passes through accept, decode, then the result register load.
// a byte that starts a match copy of n bytes moves them one at a time through
// the window memory (read, then write back), and a mid-copy result load follows
// each group of eight; no new byte is accepted until the copy is done.
// results leave through a one-entry output register; a stalled output holds the
// sequencer in the copy and result states. reset is synchronous active low.
`timescale 1ns / 1ps
`default_nettype none
module lz4_block_decoder #(
    parameter int WINDOW_DEPTH     = lz4d_pkg::WINDOW_DEPTH_DEF,
    parameter int BYTES_PER_RESULT = lz4d_pkg::BYTES_PER_RESULT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // [63:0] out_bytes, [67:64] byte_count,
                                             // [69:68] status, zero above
    output logic             m_axis_tlast,   // run_last
    input  wire logic        i_cfg_we,
    input  wire logic [lz4d_pkg::CFG_ADDR_W-1:0] i_cfg_idx,
    input  wire logic [lz4d_pkg::LEN_W-1:0]      i_cfg_data
);
    import lz4d_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(BYTES_PER_RESULT + 1);

    logic [7:0] r_win [WINDOW_DEPTH];
    logic [7:0] r_rd_data;

    t_state r_state, n_state;
    t_phase r_phase;
    logic [3:0]  r_nib;
    logic [23:0] r_lit, r_in_len, r_out_cap, r_cons, r_prod;
    logic [15:0] r_dist;
    logic [1:0]  r_fin;
    logic [8:0]  r_copy;       // match bytes still to copy
    logic [7:0]  r_byte;
    logic [CW-1:0] r_cnt;      // bytes packed in r_pack
    logic [63:0] r_pack;

    // output register
    logic        r_ov;
    logic [63:0] r_obytes;
    logic [3:0]  r_ocnt;
    logic [1:0]  r_ostat;
    logic        r_olast;

    wire in_fire  = s_axis_tvalid && s_axis_tready;
    wire out_free = !r_ov || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b0, r_ostat, r_ocnt, r_obytes};
    assign m_axis_tlast  = r_olast;

    // decode of one consumed byte, evaluated in S_DECIDE
    logic [25:0] w_ip, w_op, w_lit;
    logic [24:0] w_sum;
    logic [23:0] w_ext_lit;
    logic [15:0] w_off;
    logic [8:0]  w_add;
    logic        w_last, w_bad, w_ext_go, w_off_bad, w_tail_bad, w_grow_bad, w_copy_go;
    t_phase      w_dec_phase;
    logic [1:0]  w_dec_fin;
    always_comb begin
        w_ip  = {2'b0, r_cons};
        w_op  = {2'b0, r_prod};
        w_sum = {1'b0, r_lit} + {17'b0, r_byte};
        w_ext_lit = w_sum[24] ? 24'hFFFFFF : w_sum[23:0];
        // literal count after this byte: token nibble or grown extension
        w_lit = (r_phase == PH_LIT_EXT) ? {2'b0, w_ext_lit} : {22'b0, r_byte[7:4]};
        w_last = (w_op + w_lit + 26'(END_GAP_OUT) > {2'b0, r_out_cap}) ||
                 (w_ip + w_lit + 26'(END_GAP_IN) > {2'b0, r_in_len});
        w_bad  = (w_ip + w_lit != {2'b0, r_in_len}) || (w_op + w_lit > {2'b0, r_out_cap});
        w_ext_go = (w_ip + 26'(RUN_MAX) < {2'b0, r_in_len});
        w_dec_phase = r_phase;
        w_dec_fin   = r_fin;
        if (w_last) begin
            if (w_bad) w_dec_fin = ST_ERROR;
            else if (w_lit == 26'd0) w_dec_fin = ST_DONE;
            else w_dec_phase = PH_LAST_LITS;
        end else begin
            w_dec_phase = (w_lit == 26'd0) ? PH_OFF_LO : PH_LITERALS;
        end
        w_off = {r_byte, r_dist[7:0]};
        w_off_bad = (w_off == 16'd0) || ({8'b0, w_off} > r_prod) ||
                    (32'(w_off) > 32'(WINDOW_DEPTH));
        w_add = (r_phase == PH_OFF_HI) ? 9'(r_nib) + 9'(MIN_MATCH) :
                9'(r_byte) + ((r_nib == RUN_MAX) ? 9'(RUN_MAX) + 9'(MIN_MATCH) : 9'd0);
        w_tail_bad = (w_ip + 26'(MATCH_TAIL) > {2'b0, r_in_len});
        w_grow_bad = (w_op + 26'(w_add) + 26'(MATCH_TAIL) > {2'b0, r_out_cap});
        w_copy_go = 1'b0;
        if (r_state == S_DECIDE && r_fin == ST_RUNNING) begin
            if (r_phase == PH_OFF_HI)
                w_copy_go = !w_off_bad && r_nib != RUN_MAX && !w_grow_bad;
            else if (r_phase == PH_MATCH_EXT)
                w_copy_go = !w_tail_bad && !w_grow_bad && w_add != 9'd0;
        end
    end

    wire flush_full = (r_cnt == CW'(BYTES_PER_RESULT));
    wire load_mid   = (r_state == S_COPY_RD) && flush_full && out_free;
    wire load_end   = (r_state == S_EMIT) && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_fire) n_state = S_DECIDE;
            S_DECIDE:  n_state = w_copy_go ? S_COPY_RD : S_EMIT;
            S_COPY_RD: if (!flush_full) n_state = S_COPY_WR;
            S_COPY_WR: n_state = (r_copy == 9'd1) ? S_EMIT : S_COPY_RD;
            S_EMIT:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory port: read in S_COPY_RD, write for literals and copies
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]  w_wdata;
    always_comb begin
        w_waddr = r_prod[AW-1:0];
        w_raddr = AW'(r_prod - {8'b0, r_dist});
        w_we = 1'b0;
        w_wdata = r_byte;
        if (r_state == S_COPY_WR) begin
            w_we = 1'b1;
            w_wdata = r_rd_data;
        end else if (r_state == S_DECIDE && r_fin == ST_RUNNING &&
                     (r_phase == PH_LITERALS || r_phase == PH_LAST_LITS)) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_win[w_waddr] <= w_wdata;
        r_rd_data <= r_win[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= PH_TOKEN; r_nib <= '0; r_lit <= '0;
            r_dist <= '0; r_cons <= '0; r_prod <= '0; r_fin <= ST_RUNNING;
            r_in_len <= '0; r_out_cap <= '0; r_copy <= '0; r_cnt <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_mid || load_end) begin
                r_ov <= 1'b1; r_obytes <= r_pack; r_ocnt <= 4'(r_cnt);
                r_ostat <= r_fin; r_olast <= load_end;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_INPUT_LENGTH) r_in_len <= i_cfg_data;
                else r_out_cap <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_pack <= '0;
                    if (in_fire) begin
                        r_byte <= s_axis_tdata;
                        if (r_fin == ST_RUNNING) r_cons <= r_cons + 24'd1;
                    end
                end
                S_DECIDE: if (r_fin == ST_RUNNING) begin
                    case (r_phase)
                        PH_TOKEN: begin
                            r_lit <= {20'b0, r_byte[7:4]};
                            r_nib <= r_byte[3:0];
                            if (r_byte[7:4] == RUN_MAX) begin
                                if (!w_ext_go) r_fin <= ST_ERROR;
                                else r_phase <= PH_LIT_EXT;
                            end else begin
                                r_phase <= w_dec_phase;
                                r_fin <= w_dec_fin;
                            end
                        end
                        PH_LIT_EXT: begin
                            r_lit <= w_ext_lit;
                            if (!(r_byte == EXT_CONTINUE && w_ext_go)) begin
                                r_phase <= w_dec_phase;
                                r_fin <= w_dec_fin;
                            end
                        end
                        PH_LITERALS, PH_LAST_LITS: begin
                            r_prod <= r_prod + 24'd1;
                            r_pack[7:0] <= r_byte;
                            r_cnt <= CW'(1);
                            if (r_lit == 24'd1 || r_lit == 24'd0) begin
                                r_lit <= '0;
                                if (r_phase == PH_LAST_LITS) r_fin <= ST_DONE;
                                else r_phase <= PH_OFF_LO;
                            end else r_lit <= r_lit - 24'd1;
                        end
                        PH_OFF_LO: begin
                            r_dist <= {8'b0, r_byte};
                            r_phase <= PH_OFF_HI;
                        end
                        PH_OFF_HI: begin
                            r_dist <= w_off;
                            if (w_off_bad) begin
                                r_fin <= ST_ERROR;
                            end else if (r_nib == RUN_MAX) begin
                                r_phase <= PH_MATCH_EXT;
                            end else begin
                                r_phase <= PH_TOKEN;
                                if (w_grow_bad) r_fin <= ST_ERROR;
                                else r_copy <= w_add;
                            end
                        end
                        PH_MATCH_EXT: begin
                            if (w_tail_bad) r_fin <= ST_ERROR;
                            else begin
                                r_nib <= '0;
                                if (r_byte != EXT_CONTINUE) r_phase <= PH_TOKEN;
                                if (w_grow_bad) r_fin <= ST_ERROR;
                                else r_copy <= w_add;
                            end
                        end
                        default: r_fin <= ST_ERROR;
                    endcase
                end
                S_COPY_RD: if (load_mid) begin
                    r_cnt <= '0;
                    r_pack <= '0;
                end
                S_COPY_WR: begin
                    r_pack[8*r_cnt +: 8] <= r_rd_data;
                    r_cnt <= r_cnt + CW'(1);
                    r_prod <= r_prod + 24'd1;
                    r_copy <= r_copy - 9'd1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(BYTES_PER_RESULT)) else $error("pack count overflow");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(r_copy != 9'd0 && r_state == S_COPY_WR))
        else $error("ready during copy");
    a_fin_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_fin) != ST_RUNNING && $past(i_rst_n) |-> r_fin == $past(r_fin))
        else $error("status left final value");
`endif
endmodule
`default_nettype wire
